FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define CHECK_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must hold on every edge outside reset.
`define CHECK_ALWAYS(label, clk, rst, cond, msg) \
  `CHECK_PROP(label, clk, rst, cond, msg)

`endif

FILE: src/ocdga_pkg.sv
`default_nettype none
package ocdga_pkg;

  // Opcodes that take arguments or act alone.
  localparam logic [7:0] OP_COL_WINDOW  = 8'h21;
  localparam logic [7:0] OP_PAGE_WINDOW = 8'h22;
  localparam logic [7:0] OP_MUX_RATIO   = 8'hA8;
  localparam logic [7:0] OP_DISPLAY_ON  = 8'hAF;
  localparam logic [7:0] OP_CONTRAST    = 8'h81;
  localparam logic [7:0] OP_OFFSET      = 8'hD3;

  // Opcode ranges.
  localparam logic [7:0] OP_COL_LOW_FIRST  = 8'h00;
  localparam logic [7:0] OP_COL_LOW_LAST   = 8'h0F;
  localparam logic [7:0] OP_COL_HIGH_FIRST = 8'h10;
  localparam logic [7:0] OP_COL_HIGH_LAST  = 8'h1F;
  localparam logic [7:0] OP_START_FIRST    = 8'h40;
  localparam logic [7:0] OP_START_LAST     = 8'h7F;
  localparam logic [7:0] OP_PAGE_FIRST     = 8'hB0;
  localparam logic [7:0] OP_PAGE_LAST      = 8'hBF;

  // Reset values.
  localparam logic [6:0] COL_LAST_RESET  = 7'd127;
  localparam logic [2:0] PAGE_LAST_RESET = 3'd7;
  localparam logic [7:0] MUX_RESET       = 8'd15;

  typedef struct packed {
    logic       write_valid;
    logic [6:0] write_column;
    logic [2:0] write_page;
    logic [7:0] write_byte;
    logic       panel_on;
    logic [5:0] start_line;
    logic [7:0] vertical_offset;
    logic [7:0] mux_ratio;
  } result_t;

endpackage
`default_nettype wire

FILE: src/ocdga_decode.sv
`default_nettype none
`include "assert_macros.svh"
module ocdga_decode import ocdga_pkg::*; #(
  parameter int PANEL_COLUMNS = 128,
  parameter int PAGE_COUNT    = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       is_data,
  input  wire logic [7:0] in_byte,
  output result_t         result
);

  localparam logic [7:0] COL_LIMIT  = 8'(PANEL_COLUMNS);
  localparam logic [7:0] COL_MAX    = 8'(PANEL_COLUMNS - 1);
  localparam logic [7:0] PAGE_LIMIT = 8'(PAGE_COUNT);
  localparam logic [7:0] PAGE_MAX   = 8'(PAGE_COUNT - 1);

  logic [7:0] col_ptr, col_ptr_next;
  logic [3:0] page_ptr, page_ptr_next;
  logic [6:0] col_first, col_first_next;
  logic [6:0] col_last, col_last_next;
  logic [2:0] page_first, page_first_next;
  logic [2:0] page_last, page_last_next;
  logic       pend_valid, pend_valid_next;
  logic [7:0] pend_op, pend_op_next;
  logic       arg_pos, arg_pos_next;
  logic       on_flag, on_flag_next;
  logic [5:0] start_line, start_line_next;
  logic [7:0] offset, offset_next;
  logic [7:0] mux, mux_next;

  logic [8:0] col_inc;
  logic [4:0] page_inc;
  logic [6:0] col_clamped;
  logic [2:0] page_clamped;

  assign col_inc      = {1'b0, col_ptr} + 9'd1;
  assign page_inc     = {1'b0, page_ptr} + 5'd1;
  assign col_clamped  = (in_byte >= COL_LIMIT) ? COL_MAX[6:0] : in_byte[6:0];
  assign page_clamped = (in_byte >= PAGE_LIMIT) ? PAGE_MAX[2:0] : in_byte[2:0];

  always_comb begin
    col_ptr_next    = col_ptr;
    page_ptr_next   = page_ptr;
    col_first_next  = col_first;
    col_last_next   = col_last;
    page_first_next = page_first;
    page_last_next  = page_last;
    pend_valid_next = pend_valid;
    pend_op_next    = pend_op;
    arg_pos_next    = arg_pos;
    on_flag_next    = on_flag;
    start_line_next = start_line;
    offset_next     = offset;
    mux_next        = mux;

    if (is_data) begin
      // Advance the column; a wrap reloads the first column and steps the page.
      if (col_inc > {2'b00, col_last}) begin
        col_ptr_next = {1'b0, col_first};
        if (page_inc > {2'b00, page_last}) begin
          page_ptr_next = {1'b0, page_first};
        end else begin
          page_ptr_next = page_inc[3:0];
        end
      end else begin
        col_ptr_next = col_inc[7:0];
      end
    end else if (pend_valid) begin
      pend_valid_next = 1'b0;
      arg_pos_next    = 1'b0;
      unique case (pend_op) inside
        OP_COL_WINDOW: begin
          if (!arg_pos) begin
            col_first_next  = col_clamped;
            col_ptr_next    = {1'b0, col_clamped};
            pend_valid_next = 1'b1;
            arg_pos_next    = 1'b1;
          end else begin
            col_last_next = col_clamped;
          end
        end
        OP_PAGE_WINDOW: begin
          if (!arg_pos) begin
            page_first_next = page_clamped;
            page_ptr_next   = {1'b0, page_clamped};
            pend_valid_next = 1'b1;
            arg_pos_next    = 1'b1;
          end else begin
            page_last_next = page_clamped;
          end
        end
        OP_MUX_RATIO: mux_next = in_byte;
        OP_OFFSET:    offset_next = in_byte;
        default: ;
      endcase
    end else begin
      arg_pos_next    = 1'b0;
      pend_valid_next = 1'b0;
      unique case (in_byte) inside
        OP_COL_WINDOW, OP_PAGE_WINDOW, OP_MUX_RATIO, OP_CONTRAST, OP_OFFSET: begin
          pend_valid_next = 1'b1;
          pend_op_next    = in_byte;
        end
        OP_DISPLAY_ON: on_flag_next = 1'b1;
        [OP_COL_LOW_FIRST:OP_COL_LOW_LAST]:   col_ptr_next = {col_ptr[7:4], in_byte[3:0]};
        [OP_COL_HIGH_FIRST:OP_COL_HIGH_LAST]: col_ptr_next = {in_byte[3:0], col_ptr[3:0]};
        [OP_START_FIRST:OP_START_LAST]:       start_line_next = in_byte[5:0];
        [OP_PAGE_FIRST:OP_PAGE_LAST]:         page_ptr_next = in_byte[3:0];
        default: ;
      endcase
    end

    result.write_valid     = is_data;
    result.write_column    = is_data ? col_ptr[6:0] : 7'd0;
    result.write_page      = is_data ? page_ptr[2:0] : 3'd0;
    result.write_byte      = is_data ? in_byte : 8'd0;
    result.panel_on        = on_flag_next;
    result.start_line      = start_line_next;
    result.vertical_offset = offset_next;
    result.mux_ratio       = mux_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_ptr    <= '0;
      page_ptr   <= '0;
      col_first  <= '0;
      col_last   <= COL_LAST_RESET;
      page_first <= '0;
      page_last  <= PAGE_LAST_RESET;
      pend_valid <= 1'b0;
      pend_op    <= '0;
      arg_pos    <= 1'b0;
      on_flag    <= 1'b0;
      start_line <= '0;
      offset     <= '0;
      mux        <= MUX_RESET;
    end else if (accept) begin
      col_ptr    <= col_ptr_next;
      page_ptr   <= page_ptr_next;
      col_first  <= col_first_next;
      col_last   <= col_last_next;
      page_first <= page_first_next;
      page_last  <= page_last_next;
      pend_valid <= pend_valid_next;
      pend_op    <= pend_op_next;
      arg_pos    <= arg_pos_next;
      on_flag    <= on_flag_next;
      start_line <= start_line_next;
      offset     <= offset_next;
      mux        <= mux_next;
    end
  end

  // The second argument is only ever awaited by the two window opcodes.
  `CHECK_ALWAYS(a_arg_pos_window, clk, rst,
    !arg_pos || (pend_valid && (pend_op == OP_COL_WINDOW || pend_op == OP_PAGE_WINDOW)),
    "second argument pending without a window opcode")
  // A data word must not disturb the argument sequencing.
  `CHECK_PROP(a_data_keeps_pending, clk, rst,
    (accept && is_data) |=> ($stable(pend_valid) && $stable(pend_op) && $stable(arg_pos)),
    "data word changed the pending opcode")
  // Nothing turns the display off once it is on.
  `CHECK_ALWAYS(a_on_sticky, clk, rst, !$fell(on_flag), "display-on flag cleared")

endmodule
`default_nettype wire

FILE: src/ocdga_out_buf.sv
`default_nettype none
`include "assert_macros.svh"
module ocdga_out_buf import ocdga_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  result_t   in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    in_accept;

  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (in_accept && out_valid && !out_ready) begin
      skid_data <= in_data;
    end
  end

  // The skid stage only fills behind an occupied output register.
  `CHECK_ALWAYS(a_skid_behind_out, clk, rst, !skid_valid || out_valid,
    "skid word held with empty output register")
  `CHECK_PROP(a_stall_fills_skid, clk, rst,
    (in_accept && out_valid && !out_ready) |=> skid_valid,
    "word accepted during a stall was not kept")
  `CHECK_PROP(a_skid_drains, clk, rst,
    (skid_valid && out_ready) |=> (out_valid && !skid_valid),
    "skid word did not move to the output register")

endmodule
`default_nettype wire

FILE: src/oled_command_decode_and_gdram_addressing.sv
// Result words reach m_axis from the output register, via the skid register when m_axis stalls.
// Throughput: one word per cycle while m_axis_tready is high; the pointer and window
// update is a single combinational pass from the state registers into the output register.
// A skid register takes one word in a stalled cycle; s_axis_tready is low while it is full.
// Reset (rst, synchronous, active high) restores full window, column and page 0,
// display off, start line 0, offset 0, multiplex ratio 15, and drops queued words.
`default_nettype none
module oled_command_decode_and_gdram_addressing import ocdga_pkg::*; #(
  parameter int PANEL_COLUMNS = 128,
  parameter int PAGE_COUNT    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  wire logic        s_axis_tuser,  // [0] is_data (1 = data byte)
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // [6:0] write_column, [9:7] write_page,
                                          // [17:10] write_byte, [18] panel_on,
                                          // [24:19] start_line, [32:25] vertical_offset,
                                          // [40:33] mux_ratio, [47:41] zero
  output logic             m_axis_tuser   // [0] write_valid
);

  result_t dec_result;
  result_t out_result;
  logic    in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  ocdga_decode #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PAGE_COUNT    (PAGE_COUNT)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .is_data (s_axis_tuser),
    .in_byte (s_axis_tdata),
    .result  (dec_result)
  );

  ocdga_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (dec_result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_result)
  );

  assign m_axis_tuser = out_result.write_valid;
  assign m_axis_tdata = {7'd0, out_result.mux_ratio, out_result.vertical_offset,
                         out_result.start_line, out_result.panel_on,
                         out_result.write_byte, out_result.write_page,
                         out_result.write_column};

endmodule
`default_nettype wire
